/* rtl/rbp_pkg.sv */
// ============================================================================
// rbp_pkg - shared types for the refcounted buffer pool
// Function, status and grant codes, the scan packet and the cell command.
// ============================================================================
package rbp_pkg;

    // Widest slot index the pool can have (256 slots)
    localparam int IDX_MAX_W = 8;

    typedef enum logic [2:0] {
        FUNC_ALLOC = 3'd0,
        FUNC_FREE  = 3'd1,
        FUNC_FORCE = 3'd2,
        FUNC_REF   = 3'd3,
        FUNC_UNREF = 3'd4
    } func_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_IDLE   = 2'd1,
        ST_NOT_ALLOC = 2'd2,
        ST_ZERO_SIZE = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        KIND_NEW     = 2'd0,
        KIND_REUSE   = 2'd1,
        KIND_RESIZE  = 2'd2,
        KIND_UNUSED  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        CELL_ALLOC   = 2'd0,
        CELL_RELEASE = 2'd1,
        CELL_SETREF  = 2'd2,
        CELL_NOP     = 2'd3
    } cell_op_t;

    typedef enum logic [1:0] {
        FSM_IDLE = 2'd0,
        FSM_EXEC = 2'd1,
        FSM_SCAN = 2'd2,
        FSM_DONE = 2'd3
    } fsm_t;

    // Search packet walking down the row of cells, one cell per cycle
    typedef struct packed {
        logic                 active;
        logic                 free_hit;
        logic                 same_hit;
        logic                 other_hit;
        logic [IDX_MAX_W-1:0] free_idx;
        logic [IDX_MAX_W-1:0] same_idx;
        logic [IDX_MAX_W-1:0] other_idx;
    } pkt_t;

    // Update broadcast to all cells; only the addressed cell acts
    typedef struct packed {
        logic                 en;
        cell_op_t             op;
        logic [IDX_MAX_W-1:0] idx;
        logic [31:0]          ref_val;
    } cell_cmd_t;

endpackage

/* rtl/rbp_in_if.sv */
// ============================================================================
// rbp_in_if - request channel
// Valid/ready channel carrying one pool request item.
// ============================================================================
interface rbp_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  func;
    logic [3:0]  slot_id;
    logic [31:0] req_size;

    modport source (output valid, func, slot_id, req_size, input ready);
    modport sink   (input valid, func, slot_id, req_size, output ready);
endinterface

/* rtl/rbp_out_if.sv */
// ============================================================================
// rbp_out_if - response channel
// Valid/ready channel carrying one pool response item.
// ============================================================================
interface rbp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [3:0]  granted_slot;
    logic [1:0]  grant_kind;
    logic [15:0] ref_after;
    logic [4:0]  pool_in_use;

    modport source (output valid, status, granted_slot, grant_kind, ref_after,
                    pool_in_use, input ready);
    modport sink   (input valid, status, granted_slot, grant_kind, ref_after,
                    pool_in_use, output ready);
endinterface

/* rtl/refcounted_buffer_pool_top.sv */
// Sequence: a request is accepted in IDLE and executed in EXEC; free, force
//   free, ref, unref and zero-size alloc then go to DONE, alloc first waits in SCAN.
// Throughput: one request at a time; a new one is accepted only back in IDLE. In
//   SCAN the search packet walks the row of slot cells, one cell per cycle, and
//   the scan ends when it leaves the row. An untaken response holds the sequencer in DONE.
// Reset (rst_n, async, active low) empties every slot and clears the count.
// ============================================================================
// refcounted_buffer_pool_top - reference-counted buffer slot pool
// Row of slot cells plus a small sequencer that reads, scans and updates them.
// ============================================================================
module refcounted_buffer_pool_top #(
    parameter int POOL_SLOTS = 16,
    parameter int REF_WIDTH  = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    rbp_in_if.sink      req,
    rbp_out_if.source   rsp
);

    localparam int CNT_W = $clog2(POOL_SLOTS + 1);

    // ------------------------------------------------------------------
    // Request hold registers, sequencer and running count
    // ------------------------------------------------------------------
    rbp_pkg::fsm_t          state_reg, state_next;
    logic [2:0]             func_reg;
    logic [3:0]             sid_reg;
    logic [31:0]            size_reg;
    logic [CNT_W-1:0]       count_reg, count_next;

    // Result waiting for the DONE state
    logic [1:0]             res_status_reg, res_status_next;
    logic [3:0]             res_slot_reg, res_slot_next;
    logic [1:0]             res_kind_reg, res_kind_next;
    logic [15:0]            res_ref_reg, res_ref_next;

    // Output register toward the response channel
    logic                   out_valid_reg, out_valid_next;
    logic [1:0]             out_status_reg;
    logic [3:0]             out_slot_reg;
    logic [1:0]             out_kind_reg;
    logic [15:0]            out_ref_reg;
    logic [4:0]             out_use_reg;

    logic                   in_fire;
    logic                   out_load;
    logic                   launch;
    rbp_pkg::cell_cmd_t     cmd;

    // ------------------------------------------------------------------
    // Row of cells; the search packet enters at cell 0
    // ------------------------------------------------------------------
    rbp_pkg::pkt_t          pkt_chain [POOL_SLOTS+1];
    logic [POOL_SLOTS-1:0]  alloc_vec;
    logic [REF_WIDTH-1:0]   refs_vec [POOL_SLOTS];
    rbp_pkg::pkt_t          last_pkt;

    always_comb
    begin
        pkt_chain[0]        = '0;
        pkt_chain[0].active = launch;
    end

    genvar gi;
    generate
        for (gi = 0; gi < POOL_SLOTS; gi++)
        begin : g_cell
            rbp_cell #(
                .CELL_IDX  (gi),
                .REF_WIDTH (REF_WIDTH)
            ) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .pkt_in  (pkt_chain[gi]),
                .pkt_out (pkt_chain[gi+1]),
                .cmd     (cmd),
                .size    (size_reg),
                .alloc   (alloc_vec[gi]),
                .refs    (refs_vec[gi])
            );
        end
    endgenerate

    assign last_pkt = pkt_chain[POOL_SLOTS];

    // ------------------------------------------------------------------
    // Read the addressed slot (single address, so a plain select)
    // ------------------------------------------------------------------
    logic                 sid_valid;
    logic                 cur_alloc;
    logic [REF_WIDTH-1:0] cur_refs;
    logic [REF_WIDTH-1:0] ref_inc;
    logic [REF_WIDTH-1:0] ref_dec;

    assign sid_valid = int'(sid_reg) < POOL_SLOTS;

    always_comb
    begin
        cur_alloc = 1'b0;
        cur_refs  = '0;
        for (int i = 0; i < POOL_SLOTS; i++)
        begin
            if (int'(sid_reg) == i)
            begin
                cur_alloc = alloc_vec[i];
                cur_refs  = refs_vec[i];
            end
        end
    end

    // Saturate at the top, stop at zero
    assign ref_inc = (cur_refs == '1) ? cur_refs : cur_refs + REF_WIDTH'(1);
    assign ref_dec = (cur_refs == '0) ? cur_refs : cur_refs - REF_WIDTH'(1);

    assign in_fire  = req.valid && req.ready;
    assign out_load = (state_reg == rbp_pkg::FSM_DONE) && (!out_valid_reg || rsp.ready);

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rbp_pkg::FSM_IDLE:
            begin
                if (in_fire)
                    state_next = rbp_pkg::FSM_EXEC;
            end
            rbp_pkg::FSM_EXEC:
            begin
                if ((func_reg == rbp_pkg::FUNC_ALLOC) && (size_reg != '0))
                    state_next = rbp_pkg::FSM_SCAN;
                else
                    state_next = rbp_pkg::FSM_DONE;
            end
            rbp_pkg::FSM_SCAN:
            begin
                if (last_pkt.active)
                    state_next = rbp_pkg::FSM_DONE;
            end
            rbp_pkg::FSM_DONE:
            begin
                if (out_load)
                    state_next = rbp_pkg::FSM_IDLE;
            end
            default:
            begin
                state_next = rbp_pkg::FSM_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Outputs of the sequencer: cell command, result, count
    // ------------------------------------------------------------------
    logic [31:0] refa32;

    always_comb
    begin
        launch          = 1'b0;
        cmd             = '0;
        cmd.op          = rbp_pkg::CELL_NOP;
        count_next      = count_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_kind_next   = res_kind_reg;
        res_ref_next    = res_ref_reg;
        refa32          = '0;

        case (state_reg)
            rbp_pkg::FSM_EXEC:
            begin
                res_status_next = rbp_pkg::ST_OK;
                res_slot_next   = sid_reg;
                res_kind_next   = rbp_pkg::KIND_NEW;
                cmd.idx         = rbp_pkg::IDX_MAX_W'(sid_reg);
                case (func_reg)
                    rbp_pkg::FUNC_ALLOC:
                    begin
                        res_slot_next = '0;
                        if (size_reg == '0)
                            res_status_next = rbp_pkg::ST_ZERO_SIZE;
                        else
                            launch = 1'b1;
                    end
                    rbp_pkg::FUNC_FREE, rbp_pkg::FUNC_FORCE:
                    begin
                        if (!sid_valid)
                        begin
                            res_status_next = rbp_pkg::ST_NOT_ALLOC;
                        end
                        else if (!cur_alloc)
                        begin
                            res_status_next = rbp_pkg::ST_NOT_ALLOC;
                            refa32          = 32'(cur_refs);
                        end
                        else if ((func_reg == rbp_pkg::FUNC_FORCE) ||
                                 (cur_refs == REF_WIDTH'(1)))
                        begin
                            cmd.en = 1'b1;
                            cmd.op = rbp_pkg::CELL_RELEASE;
                            if (count_reg != '0)
                                count_next = count_reg - CNT_W'(1);
                        end
                        else
                        begin
                            cmd.en      = 1'b1;
                            cmd.op      = rbp_pkg::CELL_SETREF;
                            cmd.ref_val = 32'(ref_dec);
                            refa32      = 32'(ref_dec);
                        end
                    end
                    rbp_pkg::FUNC_REF, rbp_pkg::FUNC_UNREF:
                    begin
                        if (!sid_valid)
                        begin
                            res_status_next = rbp_pkg::ST_NOT_ALLOC;
                        end
                        else
                        begin
                            cmd.en = 1'b1;
                            cmd.op = rbp_pkg::CELL_SETREF;
                            if (func_reg == rbp_pkg::FUNC_REF)
                                refa32 = 32'(ref_inc);
                            else
                                refa32 = 32'(ref_dec);
                            cmd.ref_val = refa32;
                        end
                    end
                    default:
                    begin
                        if (sid_valid)
                            refa32 = 32'(cur_refs);
                    end
                endcase
                res_ref_next = refa32[15:0];
            end
            rbp_pkg::FSM_SCAN:
            begin
                if (last_pkt.active)
                begin
                    // Priority: empty slot, then same-size idle, then resize
                    cmd.op = rbp_pkg::CELL_ALLOC;
                    res_ref_next = 16'd2;
                    if (last_pkt.free_hit)
                    begin
                        cmd.en        = 1'b1;
                        cmd.idx       = last_pkt.free_idx;
                        res_kind_next = rbp_pkg::KIND_NEW;
                        count_next    = count_reg + CNT_W'(1);
                    end
                    else if (last_pkt.same_hit)
                    begin
                        cmd.en        = 1'b1;
                        cmd.idx       = last_pkt.same_idx;
                        res_kind_next = rbp_pkg::KIND_REUSE;
                    end
                    else if (last_pkt.other_hit)
                    begin
                        cmd.en        = 1'b1;
                        cmd.idx       = last_pkt.other_idx;
                        res_kind_next = rbp_pkg::KIND_RESIZE;
                    end
                    else
                    begin
                        res_status_next = rbp_pkg::ST_NO_IDLE;
                        res_kind_next   = rbp_pkg::KIND_NEW;
                        res_ref_next    = '0;
                    end
                    res_slot_next = cmd.en ? cmd.idx[3:0] : 4'd0;
                end
            end
            default:
            begin
                launch = 1'b0;
            end
        endcase
    end

    // Hold the response until taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rbp_pkg::FSM_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    logic [31:0] cnt32;
    assign cnt32 = 32'(count_next);

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            func_reg <= req.func;
            sid_reg  <= req.slot_id;
            size_reg <= req.req_size;
        end
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_kind_reg   <= res_kind_next;
        res_ref_reg    <= res_ref_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_slot_reg   <= res_slot_reg;
            out_kind_reg   <= res_kind_reg;
            out_ref_reg    <= res_ref_reg;
            out_use_reg    <= cnt32[4:0];
        end
    end

    assign req.ready        = (state_reg == rbp_pkg::FSM_IDLE);
    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.granted_slot = out_slot_reg;
    assign rsp.grant_kind   = out_kind_reg;
    assign rsp.ref_after    = out_ref_reg;
    assign rsp.pool_in_use  = out_use_reg;

`ifndef ASSERT_OFF
    // Running count matches the allocated marks held in the cells
    a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
        int'(count_reg) == $countones(alloc_vec))
        else $error("pool count differs from allocated slots");

    // Search packet leaves the row only while the scan is pending
    a_pkt_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        last_pkt.active |-> (state_reg == rbp_pkg::FSM_SCAN))
        else $error("scan packet outside scan state");

    // Cells are written only while a request is being executed
    a_cmd_window: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.en |-> ((state_reg == rbp_pkg::FSM_EXEC) || (state_reg == rbp_pkg::FSM_SCAN)))
        else $error("cell command outside execute window");
`endif

endmodule

/* rtl/rbp_cell.sv */
// ============================================================================
// rbp_cell - one buffer slot
// Holds allocated mark, reference count and size of one slot; updates the
// search packet from its neighbor and applies broadcast commands.
// ============================================================================
module rbp_cell #(
    parameter int CELL_IDX  = 0,
    parameter int REF_WIDTH = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  rbp_pkg::pkt_t          pkt_in,
    output rbp_pkg::pkt_t          pkt_out,
    input  rbp_pkg::cell_cmd_t     cmd,
    input  logic [31:0]            size,
    output logic                   alloc,
    output logic [REF_WIDTH-1:0]   refs
);

    logic                 alloc_reg;
    logic [REF_WIDTH-1:0] refs_reg;
    logic [31:0]          bytes_reg;
    rbp_pkg::pkt_t        pkt_reg;
    rbp_pkg::pkt_t        pkt_next;
    logic                 idle;
    logic                 hit;

    assign idle = alloc_reg && (refs_reg == REF_WIDTH'(1));
    assign hit  = cmd.en && (cmd.idx == rbp_pkg::IDX_MAX_W'(CELL_IDX));

    // Mark the first free, same-size idle and other-size idle slot seen
    always_comb
    begin
        pkt_next = pkt_in;
        if (pkt_in.active)
        begin
            if (!alloc_reg && !pkt_in.free_hit)
            begin
                pkt_next.free_hit = 1'b1;
                pkt_next.free_idx = rbp_pkg::IDX_MAX_W'(CELL_IDX);
            end
            if (idle && (bytes_reg == size) && !pkt_in.same_hit)
            begin
                pkt_next.same_hit = 1'b1;
                pkt_next.same_idx = rbp_pkg::IDX_MAX_W'(CELL_IDX);
            end
            if (idle && (bytes_reg != size) && !pkt_in.other_hit)
            begin
                pkt_next.other_hit = 1'b1;
                pkt_next.other_idx = rbp_pkg::IDX_MAX_W'(CELL_IDX);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pkt_reg   <= '0;
            alloc_reg <= 1'b0;
            refs_reg  <= '0;
            bytes_reg <= '0;
        end
        else
        begin
            pkt_reg <= pkt_next;
            if (hit)
            begin
                case (cmd.op)
                    rbp_pkg::CELL_ALLOC:
                    begin
                        alloc_reg <= 1'b1;
                        refs_reg  <= REF_WIDTH'(2);
                        bytes_reg <= size;
                    end
                    rbp_pkg::CELL_RELEASE:
                    begin
                        alloc_reg <= 1'b0;
                        refs_reg  <= '0;
                        bytes_reg <= '0;
                    end
                    rbp_pkg::CELL_SETREF:
                    begin
                        refs_reg <= cmd.ref_val[REF_WIDTH-1:0];
                    end
                    default:
                    begin
                        refs_reg <= refs_reg;
                    end
                endcase
            end
        end
    end

    assign pkt_out = pkt_reg;
    assign alloc   = alloc_reg;
    assign refs    = refs_reg;

endmodule

/* sim/refcounted_buffer_pool_checker.sv */
`timescale 1ns / 100ps
// ============================================================================
// refcounted_buffer_pool_checker - response predictor and scoreboard
// Watches both channels, keeps its own copy of the slot pool, predicts one
// response per accepted request and compares it field by field, in order.
// ============================================================================
module refcounted_buffer_pool_checker #(
    parameter int POOL_SLOTS = 16,
    parameter int REF_WIDTH  = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    rbp_in_if           req,
    rbp_out_if          rsp,
    output int unsigned errors,
    output int unsigned pending
);

    typedef struct packed {
        rbp_pkg::status_t status;
        logic [3:0]       slot;
        rbp_pkg::kind_t   kind;
        logic [15:0]      ref_after;
        logic [4:0]       in_use;
    } pool_rsp_t;

    localparam logic [REF_WIDTH-1:0] REF_TOP = '1;

    logic                 held    [POOL_SLOTS];
    logic [REF_WIDTH-1:0] refcnt  [POOL_SLOTS];
    logic [31:0]          nbytes  [POOL_SLOTS];
    logic [4:0]           busy_slots;
    pool_rsp_t            awaited_rsp [$];
    int unsigned          fail_count = 0;

    assign errors = fail_count;

    function automatic logic [REF_WIDTH-1:0] ref_up(input logic [REF_WIDTH-1:0] r);
        return (r == REF_TOP) ? r : r + REF_WIDTH'(1);
    endfunction

    function automatic logic [REF_WIDTH-1:0] ref_down(input logic [REF_WIDTH-1:0] r);
        return (r == '0) ? r : r - REF_WIDTH'(1);
    endfunction

    // Apply one request to the pool copy and return the response it earns
    function automatic pool_rsp_t serve_request(input logic [2:0] f, input logic [3:0] sid,
                                                input logic [31:0] sz);
        pool_rsp_t r;
        logic      found;
        logic      spare_hit;
        logic      sid_ok;
        int        pick;
        int        spare_idx;
        r.status    = rbp_pkg::ST_OK;
        r.slot      = sid;
        r.kind      = rbp_pkg::KIND_NEW;
        r.ref_after = '0;
        found       = 1'b0;
        spare_hit   = 1'b0;
        sid_ok      = int'(sid) < POOL_SLOTS;
        pick        = 0;
        spare_idx   = 0;
        if (f == rbp_pkg::FUNC_ALLOC)
        begin
            r.slot = '0;
            if (sz == '0)
            begin
                r.status = rbp_pkg::ST_ZERO_SIZE;
            end
            else
            begin
                for (int i = 0; i < POOL_SLOTS; i++)
                begin
                    if (!found && !held[i])
                    begin
                        found     = 1'b1;
                        pick      = i;
                        r.kind    = rbp_pkg::KIND_NEW;
                        held[i]   = 1'b1;
                        refcnt[i] = REF_WIDTH'(1);
                        nbytes[i] = sz;
                        busy_slots++;
                    end
                end
                // Pool full: prefer an idle slot of equal size, else resize one
                for (int i = 0; i < POOL_SLOTS; i++)
                begin
                    if (!found && held[i] && refcnt[i] == REF_WIDTH'(1))
                    begin
                        if (nbytes[i] == sz)
                        begin
                            found  = 1'b1;
                            pick   = i;
                            r.kind = rbp_pkg::KIND_REUSE;
                        end
                        else if (!spare_hit)
                        begin
                            spare_hit = 1'b1;
                            spare_idx = i;
                        end
                    end
                end
                if (!found && spare_hit)
                begin
                    found             = 1'b1;
                    pick              = spare_idx;
                    r.kind            = rbp_pkg::KIND_RESIZE;
                    refcnt[spare_idx] = REF_WIDTH'(1);
                    nbytes[spare_idx] = sz;
                end
                if (found)
                begin
                    refcnt[pick] = ref_up(refcnt[pick]);
                    r.slot       = 4'(pick);
                    r.ref_after  = 16'(refcnt[pick]);
                end
                else
                begin
                    r.status = rbp_pkg::ST_NO_IDLE;
                    r.kind   = rbp_pkg::KIND_NEW;
                end
            end
        end
        else if (f == rbp_pkg::FUNC_FREE || f == rbp_pkg::FUNC_FORCE)
        begin
            if (!sid_ok)
            begin
                r.status = rbp_pkg::ST_NOT_ALLOC;
            end
            else if (!held[sid])
            begin
                r.status    = rbp_pkg::ST_NOT_ALLOC;
                r.ref_after = 16'(refcnt[sid]);
            end
            else if (f == rbp_pkg::FUNC_FORCE || refcnt[sid] == REF_WIDTH'(1))
            begin
                held[sid]   = 1'b0;
                refcnt[sid] = '0;
                nbytes[sid] = '0;
                if (busy_slots != '0)
                    busy_slots--;
            end
            else
            begin
                refcnt[sid] = ref_down(refcnt[sid]);
                r.ref_after = 16'(refcnt[sid]);
            end
        end
        else if (f == rbp_pkg::FUNC_REF || f == rbp_pkg::FUNC_UNREF)
        begin
            if (!sid_ok)
            begin
                r.status = rbp_pkg::ST_NOT_ALLOC;
            end
            else
            begin
                refcnt[sid] = (f == rbp_pkg::FUNC_REF) ? ref_up(refcnt[sid])
                                                       : ref_down(refcnt[sid]);
                r.ref_after = 16'(refcnt[sid]);
            end
        end
        else
        begin
            if (sid_ok)
                r.ref_after = 16'(refcnt[sid]);
        end
        r.in_use = busy_slots;
        return r;
    endfunction

    task automatic check_field(input string label, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t rbp_chk: %s mismatch, expected %0d actual %0d",
                     $time, label, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        pool_rsp_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < POOL_SLOTS; i++)
            begin
                held[i]   = 1'b0;
                refcnt[i] = '0;
                nbytes[i] = '0;
            end
            busy_slots = '0;
            awaited_rsp.delete();
            pending <= 0;
        end
        else
        begin
            // Compare first: a response never belongs to a request of the same edge
            if (rsp.valid && rsp.ready)
            begin
                if (awaited_rsp.size() == 0)
                begin
                    $display("%0t rbp_chk: unexpected response, expected none actual %0d/%0d",
                             $time, rsp.status, rsp.granted_slot);
                    fail_count++;
                end
                else
                begin
                    want = awaited_rsp.pop_front();
                    check_field("status", 32'(want.status), 32'(rsp.status));
                    check_field("granted_slot", 32'(want.slot), 32'(rsp.granted_slot));
                    check_field("grant_kind", 32'(want.kind), 32'(rsp.grant_kind));
                    check_field("ref_after", 32'(want.ref_after), 32'(rsp.ref_after));
                    check_field("pool_in_use", 32'(want.in_use), 32'(rsp.pool_in_use));
                end
            end
            if (req.valid && req.ready)
                awaited_rsp.push_back(serve_request(req.func, req.slot_id, req.req_size));
            pending <= awaited_rsp.size();
        end
    end

endmodule

/* sim/refcounted_buffer_pool_top_tb.sv */
`timescale 1ns / 100ps
// ============================================================================
// refcounted_buffer_pool_top_tb - testbench for the refcounted buffer pool
// Drives pool requests (directed corners, a burst of references on one slot,
// then random mixes) with random idling on both channels, and leaves
// prediction and comparison to the checker module.
// ============================================================================
module refcounted_buffer_pool_top_tb;

    localparam int          POOL_SLOTS    = 16;
    localparam int          HALF_PERIOD   = 5;
    localparam int          RANDOM_ITEMS  = 1590;
    localparam int          CALM_TAIL     = 200;
    localparam int          LONG_HOLD     = 300;
    localparam int          REF_FLOOD     = 40;
    localparam int          SETTLE_CYCLES = 2 * (POOL_SLOTS + 3);
    localparam int unsigned CYCLE_LIMIT   = 2_000_000;

    // Function codes the block decodes as no-ops
    localparam logic [2:0] FUNC_SPARE_FIRST = 3'd5;
    localparam logic [2:0] FUNC_SPARE_LAST  = 3'd7;

    typedef enum int unsigned {MIX_FILL, MIX_EVEN, MIX_DRAIN} mix_t;

    logic        clk   = 1'b0;
    logic        rst_n = 1'b0;
    int unsigned chk_errors;
    int unsigned pending;
    int unsigned cycle_count = 0;

    // Knobs shared between the source and sink processes
    int unsigned src_gap_pct    = 10;
    int unsigned sink_stall_pct = 10;
    bit          hold_request   = 1'b0;
    bit          valid_up       = 1'b0;

    rbp_in_if  req_ch ();
    rbp_out_if rsp_ch ();

    refcounted_buffer_pool_top u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    refcounted_buffer_pool_checker u_chk (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .errors  (chk_errors),
        .pending (pending)
    );

    always #HALF_PERIOD clk = ~clk;

    // Guard against a hung handshake
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("refcounted_buffer_pool_top_tb: errors");
            $finish;
        end
    end

    // Offer one item and hold it until the block takes it
    task automatic send_item(input logic [2:0] f, input logic [3:0] sid,
                             input logic [31:0] sz);
        req_ch.valid    <= 1'b1;
        req_ch.func     <= f;
        req_ch.slot_id  <= sid;
        req_ch.req_size <= sz;
        valid_up = 1'b1;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
    endtask

    // Drop valid (once per step), then leave the source idle for the time given by n
    task automatic idle_source(input int unsigned n);
        if (valid_up)
        begin
            req_ch.valid <= 1'b0;
            valid_up = 1'b0;
        end
        repeat (n) @(posedge clk);
    endtask

    task automatic maybe_gap();
        if (src_gap_pct != 0 && $urandom_range(0, 99) < src_gap_pct)
            idle_source($urandom_range(1, 9));
    endtask

    // Pending is updated by nonblocking assignment, so wait on the clock before reading it
    task automatic wait_drained();
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // Weighted function choice: fill mixes push the pool full so the reuse,
    // resize and no-idle paths open up; drain mixes empty it again.
    function automatic logic [2:0] pick_func(input mix_t mix);
        int unsigned roll;
        int unsigned w_alloc;
        int unsigned w_free;
        int unsigned w_force;
        int unsigned w_ref;
        int unsigned w_unref;
        roll = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:
            begin
                w_alloc = 55; w_free = 25; w_force = 4; w_ref = 6; w_unref = 5;
            end
            MIX_EVEN:
            begin
                w_alloc = 35; w_free = 35; w_force = 8; w_ref = 8; w_unref = 8;
            end
            default:
            begin
                w_alloc = 20; w_free = 45; w_force = 20; w_ref = 5; w_unref = 5;
            end
        endcase
        if (roll < w_alloc)
            return rbp_pkg::FUNC_ALLOC;
        roll -= w_alloc;
        if (roll < w_free)
            return rbp_pkg::FUNC_FREE;
        roll -= w_free;
        if (roll < w_force)
            return rbp_pkg::FUNC_FORCE;
        roll -= w_force;
        if (roll < w_ref)
            return rbp_pkg::FUNC_REF;
        roll -= w_ref;
        if (roll < w_unref)
            return rbp_pkg::FUNC_UNREF;
        return 3'($urandom_range(FUNC_SPARE_FIRST, FUNC_SPARE_LAST));
    endfunction

    // Mostly a few common sizes so equal-size reuse happens; the rest covers
    // zero, all ones and full-width random values.
    function automatic logic [31:0] pick_size();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 5)
            return '0;
        if (roll < 10)
            return '1;
        if (roll < 20)
            return $urandom();
        return 32'd64 << $urandom_range(0, 3);
    endfunction

    // Response sink: random stalls, plus one long hold-off on request
    initial
    begin : response_sink
        int unsigned n;
        rsp_ch.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                rsp_ch.ready <= 1'b0;
                for (n = 0; n < LONG_HOLD; n++) @(posedge clk);
            end
            else if (sink_stall_pct != 0 && $urandom_range(0, 99) < sink_stall_pct)
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    initial
    begin : stimulus
        int unsigned issued;
        int unsigned phase_no;
        int unsigned phase_len;
        int unsigned k;
        mix_t        mix;

        req_ch.valid    <= 1'b0;
        req_ch.func     <= rbp_pkg::FUNC_ALLOC;
        req_ch.slot_id  <= '0;
        req_ch.req_size <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed corners: zero size, frees of empty slots, counts on empty
        // slots, no-op codes, widest size, release at one reference, and an
        // allocated slot parked at zero references.
        send_item(rbp_pkg::FUNC_ALLOC, 4'd0, '0);        maybe_gap();
        send_item(rbp_pkg::FUNC_FREE, 4'd3, 32'd64);     maybe_gap();
        send_item(rbp_pkg::FUNC_FORCE, 4'd15, '1);       maybe_gap();
        send_item(rbp_pkg::FUNC_REF, 4'd5, '0);          maybe_gap();
        send_item(rbp_pkg::FUNC_FREE, 4'd5, '0);         maybe_gap();
        send_item(rbp_pkg::FUNC_UNREF, 4'd5, '0);        maybe_gap();
        send_item(rbp_pkg::FUNC_UNREF, 4'd5, '0);        maybe_gap();
        send_item(FUNC_SPARE_FIRST, 4'd5, $urandom());   maybe_gap();
        send_item(FUNC_SPARE_FIRST + 3'd1, 4'd10, '0);   maybe_gap();
        send_item(FUNC_SPARE_LAST, 4'd15, '1);           maybe_gap();
        send_item(rbp_pkg::FUNC_ALLOC, 4'd0, '1);        maybe_gap();
        send_item(rbp_pkg::FUNC_ALLOC, 4'd7, 32'd1);     maybe_gap();
        send_item(rbp_pkg::FUNC_FREE, 4'd0, '0);         maybe_gap();
        send_item(rbp_pkg::FUNC_FREE, 4'd0, '0);         maybe_gap();
        send_item(rbp_pkg::FUNC_UNREF, 4'd1, '0);        maybe_gap();
        send_item(rbp_pkg::FUNC_UNREF, 4'd1, '0);        maybe_gap();
        send_item(rbp_pkg::FUNC_FREE, 4'd1, '0);         maybe_gap();
        send_item(rbp_pkg::FUNC_REF, 4'd1, '0);          maybe_gap();
        send_item(rbp_pkg::FUNC_FORCE, 4'd1, '0);        maybe_gap();
        send_item(rbp_pkg::FUNC_ALLOC, 4'd0, 32'd64);    maybe_gap();

        // Push a run of references onto one allocated slot, then step down
        // once and force it out. No idling here, to keep it short.
        src_gap_pct    = 0;
        sink_stall_pct = 0;
        for (k = 0; k < REF_FLOOD; k++)
            send_item(rbp_pkg::FUNC_REF, 4'd0, '0);
        send_item(rbp_pkg::FUNC_UNREF, 4'd0, '0);
        send_item(rbp_pkg::FUNC_FORCE, 4'd0, '0);
        idle_source(0);
        wait_drained();

        // Random phases, each with its own mix and idling; the tail is calm
        issued   = 0;
        phase_no = 0;
        while (issued < RANDOM_ITEMS)
        begin
            phase_len = $urandom_range(40, 120);
            mix = (phase_no == 0) ? MIX_FILL : mix_t'($urandom_range(0, 2));
            if (issued + CALM_TAIL >= RANDOM_ITEMS || $urandom_range(0, 3) == 0)
            begin
                src_gap_pct    = 0;
                sink_stall_pct = 0;
            end
            else
            begin
                src_gap_pct    = $urandom_range(5, 30);
                sink_stall_pct = $urandom_range(5, 25);
            end
            // Back-pressure the output long enough to stall the request side
            if (phase_no == 1)
                hold_request = 1'b1;
            for (k = 0; k < phase_len && issued < RANDOM_ITEMS; k++)
            begin
                send_item(pick_func(mix), 4'($urandom_range(0, POOL_SLOTS - 1)),
                          pick_size());
                maybe_gap();
                issued++;
            end
            // In every fourth phase, hold the source until every response is back
            if (phase_no % 4 == 2)
            begin
                idle_source(0);
                wait_drained();
            end
            phase_no++;
        end

        // Drain, let the block settle, then give the verdict
        idle_source(0);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (chk_errors == 0)
            $display("refcounted_buffer_pool_top_tb: clean");
        else
            $display("refcounted_buffer_pool_top_tb: errors");
        $finish;
    end

endmodule
